// ----- rtl/relocation_patch_stream_top_assert.svh -----
// ----------------------------------------------------------------------------
// Relocation patch stream assertion macros
// Shared concurrent assertion forms used by the RTL modules.
// ----------------------------------------------------------------------------
`ifndef RELOCATION_PATCH_STREAM_TOP_ASSERT_SVH
`define RELOCATION_PATCH_STREAM_TOP_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define RPS_ASSERT_HOLD(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// An antecedent that implies a consequent at the following clock edge.
`define RPS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/rps_pkg.sv -----
// ----------------------------------------------------------------------------
// Relocation patch stream package
// Shared types and codes for the front, queue and back of the patcher.
// ----------------------------------------------------------------------------
`default_nettype none

package rps_pkg;

  localparam logic [1:0] REQ_BEGIN  = 2'd0;
  localparam logic [1:0] REQ_RECORD = 2'd1;
  localparam logic [1:0] REQ_WORD   = 2'd2;

  localparam logic [1:0] SEG_CODE   = 2'd0;
  localparam logic [1:0] SEG_RODATA = 2'd1;
  localparam logic [1:0] SEG_DATA   = 2'd2;

  localparam logic KIND_ABS = 1'b0;
  localparam logic KIND_REL = 1'b1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_BAD_ABS = 2'd1;
  localparam logic [1:0] STATUS_BAD_REL = 2'd2;

  localparam logic [1:0] CFG_BASE_ADDR    = 2'd0;
  localparam logic [1:0] CFG_CODE_PAGES   = 2'd1;
  localparam logic [1:0] CFG_RODATA_PAGES = 2'd2;
  localparam logic [1:0] CFG_DATA_PAGES   = 2'd3;

  localparam logic [3:0] SUB_PLAIN     = 4'd0;
  localparam logic [3:0] SUB_REL_CLEAR = 4'd1;

  localparam logic [31:0] OFFSET_MASK = 32'h0FFF_FFFF;
  localparam logic [31:0] CLEAR_TOP   = 32'h7FFF_FFFF;
  localparam logic [25:0] POS_MAX     = 26'h3FF_FFFF;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [31:0] word;
    logic        do_patch;
    logic        kind;
    logic [31:0] rel;
    logic        done;
  } op_t;

  typedef struct packed {
    logic [31:0] word;
    logic        patched;
    logic [1:0]  status;
    logic        run_done;
  } res_t;

  typedef struct packed {
    logic [15:0] code_pages;
    logic [15:0] rodata_pages;
    logic [15:0] data_pages;
  } pages_t;

endpackage

`default_nettype wire

// ----- rtl/rps_front.sv -----
// ----------------------------------------------------------------------------
// Relocation patch stream front
// Accepts items, tracks position and run counters, and classifies each word.
// ----------------------------------------------------------------------------
`default_nettype none

module rps_front #(
  parameter int MAX_PAGES = 65535
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           accept,
  input  wire logic [1:0]     req_type,
  input  wire logic [1:0]     segment,
  input  wire logic           table_kind,
  input  wire logic [15:0]    skip_count,
  input  wire logic [15:0]    patch_count,
  input  wire logic [31:0]    word_in,
  input  wire rps_pkg::pages_t pages,
  output logic                op_valid,
  output rps_pkg::op_t        op
);
  import rps_pkg::*;

  localparam logic [15:0] PAGE_LIMIT = 16'(MAX_PAGES);

  logic [25:0] word_pos;
  logic [15:0] skip_left;
  logic [15:0] patch_left;
  logic [1:0]  cur_segment;
  logic        cur_kind;

  logic [25:0] word_pos_next;
  logic [15:0] skip_left_next;
  logic [15:0] patch_left_next;

  logic [15:0] code_cl;
  logic [15:0] rodata_cl;
  logic [15:0] data_cl;
  logic [15:0] seg_pages;
  logic [16:0] start_pages;
  logic [25:0] seg_end;
  logic        in_seg;
  logic        do_patch;

  always_comb begin
    code_cl   = (pages.code_pages > PAGE_LIMIT) ? PAGE_LIMIT : pages.code_pages;
    rodata_cl = (pages.rodata_pages > PAGE_LIMIT) ? PAGE_LIMIT : pages.rodata_pages;
    data_cl   = (pages.data_pages > PAGE_LIMIT) ? PAGE_LIMIT : pages.data_pages;
    unique case (cur_segment)
      SEG_CODE: begin
        seg_pages   = code_cl;
        start_pages = 17'd0;
      end
      SEG_RODATA: begin
        seg_pages   = rodata_cl;
        start_pages = {1'b0, code_cl};
      end
      SEG_DATA: begin
        seg_pages   = data_cl;
        start_pages = {1'b0, code_cl} + {1'b0, rodata_cl};
      end
      default: begin
        seg_pages   = 16'd0;
        start_pages = {1'b0, code_cl} + {1'b0, rodata_cl};
      end
    endcase
    seg_end = {seg_pages, 10'd0};
    in_seg  = word_pos < seg_end;
  end

  always_comb begin
    skip_left_next  = skip_left;
    patch_left_next = patch_left;
    do_patch        = 1'b0;
    if (skip_left != 16'd0) begin
      skip_left_next = skip_left - 16'd1;
    end else if (patch_left != 16'd0) begin
      patch_left_next = patch_left - 16'd1;
      do_patch        = in_seg;
    end
    word_pos_next = (word_pos < POS_MAX) ? word_pos + 26'd1 : word_pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_pos    <= '0;
      skip_left   <= '0;
      patch_left  <= '0;
      cur_segment <= SEG_CODE;
      cur_kind    <= KIND_ABS;
    end else if (accept) begin
      priority case (req_type)
        REQ_BEGIN: begin
          cur_segment <= segment;
          cur_kind    <= table_kind;
          word_pos    <= '0;
          skip_left   <= '0;
          patch_left  <= '0;
        end
        REQ_RECORD: begin
          skip_left  <= skip_count;
          patch_left <= patch_count;
        end
        REQ_WORD: begin
          word_pos   <= word_pos_next;
          skip_left  <= skip_left_next;
          patch_left <= patch_left_next;
        end
        default: begin
        end
      endcase
    end
  end

  // The self address minus base_addr; the base cancels in the relative difference.
  always_comb begin
    op_valid    = accept && (req_type == REQ_WORD);
    op.word     = word_in;
    op.do_patch = do_patch;
    op.kind     = cur_kind;
    op.rel      = {3'd0, start_pages, 12'd0} + {4'd0, word_pos, 2'd0};
    op.done     = (skip_left_next == 16'd0) && (patch_left_next == 16'd0);
  end

endmodule

`default_nettype wire

// ----- rtl/rps_queue.sv -----
// ----------------------------------------------------------------------------
// Relocation patch stream queue
// Short register queue of classified words between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "relocation_patch_stream_top_assert.svh"

module rps_queue (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr_en,
  input  wire rps_pkg::op_t wr_op,
  input  wire logic         rd_en,
  output logic              full,
  output logic              rd_valid,
  output rps_pkg::op_t      rd_op
);
  import rps_pkg::*;

  op_t        entries [QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_wr;
  logic       do_rd;

  assign full     = count == 2'(QUEUE_DEPTH);
  assign rd_valid = count != 2'd0;
  assign rd_op    = entries[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(do_wr) - 2'(do_rd);
    end
  end

  `RPS_ASSERT_HOLD(a_count_bound, clk, rst, count <= 2'(QUEUE_DEPTH), "queue count over depth")
  `RPS_ASSERT_NEXT(a_count_up, clk, rst, do_wr && !do_rd, count == $past(count) + 2'd1, "queue count did not rise")
  `RPS_ASSERT_HOLD(a_ptr_gap, clk, rst, (count == 2'd1) == (wr_ptr != rd_ptr), "queue pointers disagree with count")

endmodule

`default_nettype wire

// ----- rtl/rps_back.sv -----
// ----------------------------------------------------------------------------
// Relocation patch stream back
// Applies the absolute or relative patch and holds the result for the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "relocation_patch_stream_top_assert.svh"

module rps_back (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic [31:0]  base_addr,
  input  wire logic         in_valid,
  input  wire rps_pkg::op_t in_op,
  output logic              in_take,
  input  wire logic         out_pop,
  output logic              out_valid,
  output rps_pkg::res_t     out_res
);
  import rps_pkg::*;

  logic [31:0] offset;
  logic [31:0] target;
  logic [31:0] diff;
  logic [3:0]  sub;
  res_t        res_next;

  always_comb begin
    offset = in_op.word & OFFSET_MASK;
    target = base_addr + offset;
    diff   = offset - in_op.rel;
    sub    = in_op.word[31:28];

    res_next.word     = in_op.word;
    res_next.patched  = 1'b0;
    res_next.status   = STATUS_OK;
    res_next.run_done = in_op.done;
    if (in_op.do_patch) begin
      if (in_op.kind == KIND_ABS) begin
        if (sub == SUB_PLAIN) begin
          res_next.word    = target;
          res_next.patched = 1'b1;
        end else begin
          res_next.status = STATUS_BAD_ABS;
        end
      end else begin
        if (sub == SUB_PLAIN) begin
          res_next.word    = diff;
          res_next.patched = 1'b1;
        end else if (sub == SUB_REL_CLEAR) begin
          res_next.word    = diff & CLEAR_TOP;
          res_next.patched = 1'b1;
        end else begin
          res_next.status = STATUS_BAD_REL;
        end
      end
    end
  end

  assign in_take = in_valid && (!out_valid || out_pop);

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take) begin
      out_valid <= 1'b1;
    end else if (out_pop) begin
      out_valid <= 1'b0;
    end
  end

  `RPS_ASSERT_HOLD(a_patch_ok, clk, rst, !(out_valid && out_res.patched) || out_res.status == STATUS_OK, "patched item with error status")
  `RPS_ASSERT_NEXT(a_fill, clk, rst, in_valid && !out_valid, out_valid, "result register not filled")

endmodule

`default_nettype wire

// ----- rtl/relocation_patch_stream_top.sv -----
// ----------------------------------------------------------------------------
// Relocation patch stream
// Relocates the words of one program segment as they stream through.
// ----------------------------------------------------------------------------
//   channel   handshake              payload
//   input     push / full            req_type segment table_kind skip_count
//                                    patch_count word_in
//   result    empty / pop            word_out patched status run_done
//   config    cfg_wr_en (no wait)    cfg_index cfg_data
//
// One item is accepted per cycle while full is low; a word item's result
// reaches the result ports through the queue entry and the result register.
// Begin, record and unknown items give no result.
// A two-entry queue parts the front from the patch stage, and a result
// register parts the patch stage from the consumer, so either side may stall.
// Synchronous reset clears the counters, configuration, queue and result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module relocation_patch_stream_top #(
  parameter int MAX_PAGES = 65535
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  req_type,
  input  wire logic [1:0]  segment,
  input  wire logic        table_kind,
  input  wire logic [15:0] skip_count,
  input  wire logic [15:0] patch_count,
  input  wire logic [31:0] word_in,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      word_out,
  output logic             patched,
  output logic [1:0]       status,
  output logic             run_done,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import rps_pkg::*;

  logic [31:0] base_addr;
  pages_t      pages;
  logic        accept;
  logic        op_valid;
  op_t         op;
  logic        q_valid;
  op_t         q_op;
  logic        q_take;
  logic        res_valid;
  res_t        res;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_addr <= '0;
      pages     <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_BASE_ADDR:    base_addr          <= cfg_data;
        CFG_CODE_PAGES:   pages.code_pages   <= cfg_data[15:0];
        CFG_RODATA_PAGES: pages.rodata_pages <= cfg_data[15:0];
        CFG_DATA_PAGES:   pages.data_pages   <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  assign accept = push && !full;

  rps_front #(
    .MAX_PAGES (MAX_PAGES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .req_type    (req_type),
    .segment     (segment),
    .table_kind  (table_kind),
    .skip_count  (skip_count),
    .patch_count (patch_count),
    .word_in     (word_in),
    .pages       (pages),
    .op_valid    (op_valid),
    .op          (op)
  );

  rps_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (op_valid),
    .wr_op    (op),
    .rd_en    (q_take),
    .full     (full),
    .rd_valid (q_valid),
    .rd_op    (q_op)
  );

  rps_back u_back (
    .clk       (clk),
    .rst       (rst),
    .base_addr (base_addr),
    .in_valid  (q_valid),
    .in_op     (q_op),
    .in_take   (q_take),
    .out_pop   (pop),
    .out_valid (res_valid),
    .out_res   (res)
  );

  assign empty    = !res_valid;
  assign word_out = res.word;
  assign patched  = res.patched;
  assign status   = res.status;
  assign run_done = res.run_done;

endmodule

`default_nettype wire

// ----- tb/tb_relocation_patch_stream_top.sv -----
// ----------------------------------------------------------------------------
// Relocation patch stream testbench
// Drives begin, record and image word items through the patcher and checks
// every word result against a cycle-free predictor of the relocation rules.
// The run covers directed corner cases, zero size segments and random
// streams under several configurations and handshake stall patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_relocation_patch_stream_top;
  import rps_pkg::*;

  localparam int          CLK_HALF    = 5;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          DRAIN_WAIT  = 8;
  localparam int          PAGE_LIMIT  = 65535;
  localparam logic [31:0] PAGE_WORDS  = 32'd1024;
  localparam logic [31:0] PAGE_BYTES  = 32'h1000;
  localparam logic [1:0]  REQ_UNUSED  = 2'd3;
  localparam logic [1:0]  SEG_NONE    = 2'd3;

  typedef struct {
    logic [1:0]  rtype;
    logic [1:0]  seg;
    logic        kind;
    logic [15:0] skip;
    logic [15:0] patch;
    logic [31:0] word;
  } patch_req_t;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        push        = 1'b0;
  logic        full;
  logic [1:0]  req_type    = '0;
  logic [1:0]  segment     = '0;
  logic        table_kind  = 1'b0;
  logic [15:0] skip_count  = '0;
  logic [15:0] patch_count = '0;
  logic [31:0] word_in     = '0;
  logic        empty;
  logic        pop         = 1'b0;
  logic [31:0] word_out;
  logic        patched;
  logic [1:0]  status;
  logic        run_done;
  logic        cfg_wr_en   = 1'b0;
  logic [1:0]  cfg_index   = '0;
  logic [31:0] cfg_data    = '0;

  // Predictor state and configuration.
  logic [31:0] m_base = '0;
  logic [15:0] m_pages [3] = '{16'd0, 16'd0, 16'd0};
  logic [25:0] m_pos = '0;
  logic [15:0] m_skip = '0;
  logic [15:0] m_patch_left = '0;
  logic [1:0]  m_seg = SEG_CODE;
  logic        m_kind = KIND_ABS;

  res_t expected_words [$];
  res_t exp_res;
  int   errors = 0;
  int   items_sent = 0;
  int   results_checked = 0;
  int   cycle_count = 0;
  int   push_idle_pct = 0;
  int   pop_idle_pct = 0;

  relocation_patch_stream_top dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .req_type(req_type), .segment(segment), .table_kind(table_kind),
    .skip_count(skip_count), .patch_count(patch_count), .word_in(word_in),
    .empty(empty), .pop(pop), .word_out(word_out), .patched(patched),
    .status(status), .run_done(run_done),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [31:0] page_count(input logic [1:0] seg);
    logic [31:0] p;
    p = (seg == SEG_NONE) ? 32'd0 : {16'd0, m_pages[seg]};
    return (p > PAGE_LIMIT) ? PAGE_LIMIT : p;
  endfunction

  function automatic bit relocate_item(input patch_req_t it, output res_t r);
    logic [31:0] target, self_addr, diff, start;
    logic [3:0]  sub;
    r.word     = it.word;
    r.patched  = 1'b0;
    r.status   = STATUS_OK;
    r.run_done = 1'b0;
    case (it.rtype)
      REQ_BEGIN: begin
        m_seg        = it.seg;
        m_kind       = it.kind;
        m_pos        = '0;
        m_skip       = '0;
        m_patch_left = '0;
        return 1'b0;
      end
      REQ_RECORD: begin
        m_skip       = it.skip;
        m_patch_left = it.patch;
        return 1'b0;
      end
      REQ_WORD: ;
      default: return 1'b0;
    endcase
    if (m_skip != 0) begin
      m_skip = m_skip - 1'b1;
    end else if (m_patch_left != 0) begin
      m_patch_left = m_patch_left - 1'b1;
      if ({6'd0, m_pos} < page_count(m_seg) * PAGE_WORDS) begin
        sub    = it.word[31:28];
        target = m_base + (it.word & OFFSET_MASK);
        if (m_kind == KIND_ABS) begin
          if (sub == SUB_PLAIN) begin
            r.word    = target;
            r.patched = 1'b1;
          end else begin
            r.status = STATUS_BAD_ABS;
          end
        end else begin
          start = 32'd0;
          if (m_seg >= SEG_RODATA) start = start + page_count(SEG_CODE);
          if (m_seg >= SEG_DATA) start = start + page_count(SEG_RODATA);
          self_addr = m_base + start * PAGE_BYTES + {4'd0, m_pos, 2'b00};
          diff      = target - self_addr;
          if (sub == SUB_PLAIN) begin
            r.word    = diff;
            r.patched = 1'b1;
          end else if (sub == SUB_REL_CLEAR) begin
            r.word    = diff & CLEAR_TOP;
            r.patched = 1'b1;
          end else begin
            r.status = STATUS_BAD_REL;
          end
        end
      end
    end
    if (m_pos != POS_MAX) m_pos = m_pos + 1'b1;
    r.run_done = (m_skip == 0) && (m_patch_left == 0);
    return 1'b1;
  endfunction

  function automatic patch_req_t mk_any();
    patch_req_t it;
    it.rtype = 2'($urandom);
    it.seg   = 2'($urandom);
    it.kind  = 1'($urandom);
    it.skip  = 16'($urandom);
    it.patch = 16'($urandom);
    it.word  = $urandom;
    return it;
  endfunction

  function automatic patch_req_t mk_begin(input logic [1:0] seg, input logic kind);
    patch_req_t it;
    it       = mk_any();
    it.rtype = REQ_BEGIN;
    it.seg   = seg;
    it.kind  = kind;
    return it;
  endfunction

  function automatic patch_req_t mk_record(input logic [15:0] skip, input logic [15:0] cnt);
    patch_req_t it;
    it       = mk_any();
    it.rtype = REQ_RECORD;
    it.skip  = skip;
    it.patch = cnt;
    return it;
  endfunction

  function automatic patch_req_t mk_word(input logic [31:0] w);
    patch_req_t it;
    it       = mk_any();
    it.rtype = REQ_WORD;
    it.word  = w;
    return it;
  endfunction

  function automatic logic [31:0] random_word();
    int r;
    logic [3:0] sub;
    r = $urandom_range(0, 9);
    if (r < 4) sub = SUB_PLAIN;
    else if (r < 7) sub = SUB_REL_CLEAR;
    else sub = 4'($urandom);
    return {sub, 28'($urandom)};
  endfunction

  function automatic logic [15:0] random_pages();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'hFFFF;
    if (r == 2) return 16'($urandom);
    return 16'($urandom_range(1, 3));
  endfunction

  task automatic send_item(input patch_req_t it);
    res_t r;
    if (push_idle_pct != 0 && $urandom_range(0, 99) < push_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < push_idle_pct);
    end
    push        <= 1'b1;
    req_type    <= it.rtype;
    segment     <= it.seg;
    table_kind  <= it.kind;
    skip_count  <= it.skip;
    patch_count <= it.patch;
    word_in     <= it.word;
    do @(posedge clk); while (full);
    if (relocate_item(it, r)) expected_words.push_back(r);
    if (it.rtype != REQ_UNUSED) items_sent++;
  endtask

  task automatic wait_drain();
    push <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_BASE_ADDR:    m_base = data;
      CFG_CODE_PAGES:   m_pages[0] = data[15:0];
      CFG_RODATA_PAGES: m_pages[1] = data[15:0];
      CFG_DATA_PAGES:   m_pages[2] = data[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] base, input logic [15:0] code,
                            input logic [15:0] ro, input logic [15:0] dat);
    write_reg(CFG_BASE_ADDR, base);
    write_reg(CFG_CODE_PAGES, {16'($urandom), code});
    write_reg(CFG_RODATA_PAGES, {16'($urandom), ro});
    write_reg(CFG_DATA_PAGES, {16'($urandom), dat});
    cfg_wr_en <= 1'b0;
  endtask

  task automatic test_before_begin();
    send_item(mk_word(32'h0000_0000));
    send_item(mk_word(32'hFFFF_FFFF));
    send_item(mk_record(16'd0, 16'd1));
    send_item(mk_word(32'h0000_0040));
  endtask

  task automatic test_absolute();
    wait_drain();
    set_config(32'h1000_0000, 16'd4, 16'd2, 16'd3);
    send_item(mk_begin(SEG_CODE, KIND_ABS));
    send_item(mk_record(16'd1, 16'd3));
    send_item(mk_word(32'h0123_4567));
    send_item(mk_word(32'h0FFF_FFFF));
    send_item(mk_word(32'h0000_0000));
    send_item(mk_word(32'hF000_0001));
    send_item(mk_word(32'h0000_0010));
  endtask

  task automatic test_relative();
    send_item(mk_begin(SEG_RODATA, KIND_REL));
    send_item(mk_record(16'd0, 16'd5));
    send_item(mk_word(32'h0000_2000));
    send_item(mk_word(32'h1FFF_FFFF));
    send_item(mk_record(16'd1, 16'd1));
    send_item(mk_word(32'h0000_0004));
    send_item(mk_word(32'h0000_0008));
    send_item(mk_begin(SEG_DATA, KIND_REL));
    send_item(mk_record(16'd0, 16'd2));
    send_item(mk_word(32'h2000_0010));
    send_item(mk_word(32'hFFFF_FFFF));
    send_item(mk_begin(SEG_NONE, KIND_ABS));
    send_item(mk_record(16'd0, 16'd1));
    send_item(mk_word(32'h0000_0100));
  endtask

  task automatic test_extremes();
    patch_req_t it;
    wait_drain();
    set_config(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(mk_begin(SEG_DATA, KIND_REL));
    send_item(mk_record(16'd0, 16'hFFFF));
    send_item(mk_word(32'h0FFF_FFFF));
    send_item(mk_word(32'h1000_0000));
    send_item(mk_record(16'hFFFF, 16'hFFFF));
    send_item(mk_word(32'h0000_0000));
    it       = mk_word(32'h0000_0000);
    it.rtype = REQ_UNUSED;
    send_item(it);
  endtask

  task automatic test_segment_end();
    wait_drain();
    set_config(32'h8000_0000, 16'd0, 16'd1, 16'd0);
    send_item(mk_begin(SEG_CODE, KIND_ABS));
    send_item(mk_record(16'd0, 16'd3));
    send_item(mk_word(32'h0000_0100));
    send_item(mk_word(32'h0000_0200));
    send_item(mk_begin(SEG_DATA, KIND_REL));
    send_item(mk_record(16'd1, 16'd2));
    send_item(mk_word(32'h0000_0300));
    send_item(mk_word(32'h1000_0400));
    send_item(mk_word(32'h0000_0500));
    send_item(mk_begin(SEG_RODATA, KIND_REL));
    send_item(mk_record(16'd0, 16'd2));
    send_item(mk_word(32'h0000_0600));
    send_item(mk_word(32'h1000_0700));
  endtask

  task automatic run_random_block(input int n_items);
    int start_count, nrec, nwords, r;
    logic [15:0] sk, pc;
    logic [31:0] base;
    start_count = items_sent;
    wait_drain();
    r = $urandom_range(0, 9);
    base = (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
    set_config(base, random_pages(), random_pages(), random_pages());
    while (items_sent - start_count < n_items) begin
      if ($urandom_range(0, 99) < 80) begin
        r = $urandom_range(0, 9);
        send_item(mk_begin((r == 9) ? SEG_NONE : 2'(r % 3), 1'($urandom)));
        nrec = $urandom_range(1, 3);
        for (int i = 0; i < nrec; i++) begin
          if ($urandom_range(0, 9) == 0) begin
            sk     = 16'($urandom);
            pc     = 16'($urandom);
            nwords = $urandom_range(1, 4);
          end else begin
            sk     = 16'($urandom_range(0, 3));
            pc     = 16'($urandom_range(1, 6));
            nwords = sk + pc + $urandom_range(0, 2);
            if ($urandom_range(0, 9) == 0) nwords = $urandom_range(0, sk + pc);
          end
          send_item(mk_record(sk, pc));
          for (int j = 0; j < nwords; j++) send_item(mk_word(random_word()));
        end
      end else begin
        send_item(mk_any());
      end
    end
  endtask

  task automatic test_random();
    int push_rates [3] = '{35, 88, 0};
    int pop_rates [3]  = '{88, 35, 0};
    for (int p = 0; p < 3; p++) begin
      push_idle_pct = push_rates[p];
      pop_idle_pct  = pop_rates[p];
      for (int b = 0; b < 4; b++) run_random_block(60);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result: word_out=%h patched=%b status=%0d run_done=%b",
                 word_out, patched, status, run_done);
          errors++;
        end else begin
          exp_res = expected_words.pop_front();
          results_checked++;
          if (word_out !== exp_res.word) begin
            $error("word_out: expected %h, got %h", exp_res.word, word_out);
            errors++;
          end
          if (patched !== exp_res.patched) begin
            $error("patched: expected %b, got %b", exp_res.patched, patched);
            errors++;
          end
          if (status !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, status);
            errors++;
          end
          if (run_done !== exp_res.run_done) begin
            $error("run_done: expected %b, got %b", exp_res.run_done, run_done);
            errors++;
          end
        end
      end
      pop <= ($urandom_range(0, 99) >= pop_idle_pct);
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_before_begin();
    test_absolute();
    test_relative();
    test_extremes();
    test_segment_end();
    test_random();
    wait_drain();
    $display("Sent %0d items and checked %0d word results across directed, zero size",
             items_sent, results_checked);
    $display("segment and random streams under three stall patterns and many configurations.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- relocation_patch_stream_top.f -----
+incdir+rtl
rtl/rps_pkg.sv
rtl/rps_front.sv
rtl/rps_queue.sv
rtl/rps_back.sv
rtl/relocation_patch_stream_top.sv
tb/tb_relocation_patch_stream_top.sv
